FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define YCID_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ycid assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define YCID_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ycid assertion failed");

`endif

FILE: rtl/core/ycid_pkg.sv
package ycid_pkg;

	localparam int DAY_W  = 16;
	localparam int RATE_W = 32;
	localparam int DF_W   = 32;
	localparam int FRAC_W = 30;
	localparam int DIV_W  = 48;
	localparam int DVS_W  = 30;

	localparam logic [FRAC_W-1:0] LN2_Q30  = 30'd744261118;
	localparam logic [FRAC_W:0]   ONE_Q30  = 31'h4000_0000;
	localparam logic [32:0]       BP_Q30   = 33'd107374;
	localparam logic [DF_W-1:0]   ONE_Q28  = 32'h1000_0000;
	localparam logic [DF_W-1:0]   DF_MAX   = 32'hFFFF_FFFF;
	localparam logic [3:0]        TAYLOR_N = 4'd12;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic CFG_PILLAR_COUNT = 1'b0;
	localparam logic CFG_YEAR_BASIS   = 1'b1;

	localparam logic [4:0] PILLAR_COUNT_RESET = 5'd2;
	localparam logic [9:0] YEAR_BASIS_RESET   = 10'd365;

	localparam logic [1:0] VAR_BASE = 2'd0;
	localparam logic [1:0] VAR_UP   = 2'd1;
	localparam logic [1:0] VAR_DOWN = 2'd2;

	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [DAY_W-1:0]  q;
		logic [DAY_W-1:0]  a;
		logic [DAY_W-1:0]  b;
		logic [RATE_W-1:0] r0;
		logic [RATE_W-1:0] r1;
	} tok_t;

	typedef struct packed {
		logic [30:0] m;
		logic [5:0]  sh;
	} recip_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEARCH, ST_IMUL, ST_ISTART, ST_IWAIT, ST_PMUL, ST_BSTART,
		ST_BWAIT, ST_LSTART, ST_LWAIT, ST_ESTART, ST_EWAIT, ST_NEXT, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		EX_IDLE, EX_MUL, EX_REC, EX_ACC, EX_DONE
	} exp_state_t;

	// floor(x/n) = (x*m) >> sh for every x below 2^30
	function automatic recip_t recip(input logic [3:0] n);
		recip_t r;
		case (n)
			4'd2:    r = '{m: 31'd1073741824, sh: 6'd31};
			4'd3:    r = '{m: 31'd1431655766, sh: 6'd32};
			4'd4:    r = '{m: 31'd1073741824, sh: 6'd32};
			4'd5:    r = '{m: 31'd1717986919, sh: 6'd33};
			4'd6:    r = '{m: 31'd1431655766, sh: 6'd33};
			4'd7:    r = '{m: 31'd1227133514, sh: 6'd33};
			4'd8:    r = '{m: 31'd1073741824, sh: 6'd33};
			4'd9:    r = '{m: 31'd1908874354, sh: 6'd34};
			4'd10:   r = '{m: 31'd1717986919, sh: 6'd34};
			4'd11:   r = '{m: 31'd1561806290, sh: 6'd34};
			4'd12:   r = '{m: 31'd1431655766, sh: 6'd34};
			default: r = '{m: 31'd1073741824, sh: 6'd30};
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/yield_curve_interp_discount.sv
// Piecewise-linear yield curve with discount factors. A word on s_tuser = 0 loads one pillar
// (day, Q2.30 rate) into the cell picked by its index and answers an all-zero result;
// s_tuser = 1 asks about a day and answers the interpolated rate and the discount factors
// exp(-r*t), exp(-(r+1bp)*t), exp(-(r-1bp)*t) in Q4.28, t = day / year basis. One word is worked
// on at a time. For a query the day walks the pillar cells one a cycle to find its segment, then
// a shared 48-step divider runs up to four times (interpolation, then per factor the year
// scaling), per factor ln2 is taken off once a cycle at most 32 times, and an exponential
// series through its 12th term runs up to three times, each term in a multiply, reciprocal and
// accumulate step. Days outside the pillars answer rate 0, discounts 1.0 and out_of_range; a
// factor clamped at its maximum sets saturated. Read only pillars once written.
module yield_curve_interp_discount #(
	parameter int MAX_PILLARS = 16,
	parameter int MAX_DAYS    = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [9:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pillar_index[3:0], pillar_day[19:4], pillar_rate[51:20], query_day[67:52], zero pad
	input  logic [71:0]  s_tdata,
	// cmd[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rate[31:0], discount[63:32], discount_up[95:64], discount_down[127:96]
	output logic [127:0] m_tdata,
	// out_of_range[0], saturated[1]
	output logic [1:0]   m_tuser
);

	localparam int NW = $clog2(MAX_PILLARS + 1);
	localparam int DW = ycid_pkg::DAY_W;
	localparam int RW = ycid_pkg::RATE_W;

	ycid_pkg::state_t st_q;
	ycid_pkg::state_t st_d;

	logic [4:0]        pc_q;
	logic [9:0]        basis_q;
	logic [9:0]        basis_eff;
	logic [NW-1:0]     n_eff;

	logic              acc_in;
	logic [3:0]        in_idx;
	logic [DW-1:0]     in_day;
	logic [RW-1:0]     in_rate;
	logic [DW-1:0]     in_q;

	ycid_pkg::tok_t    tok [MAX_PILLARS+1];
	logic [DW-1:0]     day_a [MAX_PILLARS];
	logic [RW-1:0]     rate_a [MAX_PILLARS];
	ycid_pkg::tok_t    tok_end;
	logic              in_days;

	logic [DW-1:0]     q_q;
	logic [DW-1:0]     a_q;
	logic [DW-1:0]     b_q;
	logic [RW-1:0]     r0_q;
	logic [RW-1:0]     r1_q;
	logic [RW-1:0]     rate_q;
	logic [1:0]        var_q;
	logic [49:0]       num_s1;
	logic [49:0]       p_s1;
	logic [49:0]       num_abs;
	logic [49:0]       p_abs;
	logic              xpos;
	logic [ycid_pkg::DIV_W-1:0] mag_q;
	logic [ycid_pkg::DIV_W-1:0] red_q;
	logic [5:0]                 kk_q;
	logic                       ln2_sub;
	logic [ycid_pkg::DVS_W-1:0] rem_q;
	logic [ycid_pkg::DF_W-1:0]  df_q [3];
	logic              oor_q;
	logic              sat_q;
	logic              big_k;
	logic [32:0]       rr;
	logic [32:0]       diff;

	logic                       div_start;
	logic [ycid_pkg::DIV_W-1:0] div_dividend;
	logic [ycid_pkg::DVS_W-1:0] div_divisor;
	logic                       div_done;
	logic [ycid_pkg::DIV_W-1:0] div_quot;

	logic                        exp_start;
	logic [ycid_pkg::FRAC_W-1:0] exp_f;
	logic                        exp_done;
	logic [ycid_pkg::DF_W-1:0]   exp_e;
	logic [5:0]                  sh;
	logic [32:0]                 v;

	logic                m_tvalid_q;
	logic [127:0]        m_tdata_q;
	logic [1:0]          m_tuser_q;
	logic                out_go;

	assign in_idx  = s_tdata[3:0];
	assign in_day  = s_tdata[19:4];
	assign in_rate = s_tdata[51:20];
	assign in_q    = s_tdata[67:52];
	assign acc_in  = s_tvalid && s_tready;
	assign out_go  = !m_tvalid_q || m_tready;

	assign basis_eff = (basis_q == '0) ? 10'd1 : basis_q;

	always_comb begin
		if (32'(pc_q) < 2) begin
			n_eff = NW'(2);
		end else if (32'(pc_q) > MAX_PILLARS) begin
			n_eff = NW'(MAX_PILLARS);
		end else begin
			n_eff = NW'(pc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= ycid_pkg::PILLAR_COUNT_RESET;
			basis_q <= ycid_pkg::YEAR_BASIS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ycid_pkg::CFG_PILLAR_COUNT: pc_q    <= cfg_data[4:0];
				ycid_pkg::CFG_YEAR_BASIS:   basis_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// segment search: the query word walks the pillar cells
	assign tok[0] = '{valid: acc_in && (s_tuser == ycid_pkg::CMD_QUERY), q: in_q, default: '0};

	for (genvar i = 0; i < MAX_PILLARS; i++) begin : g_cell
		logic [DW-1:0] nd;
		logic [RW-1:0] nr;
		if (i < MAX_PILLARS - 1) begin : g_mid
			assign nd = day_a[i+1];
			assign nr = rate_a[i+1];
		end else begin : g_end
			assign nd = '0;
			assign nr = '0;
		end
		ycid_cell #(.IDX(i), .NW(NW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.we       (acc_in && (s_tuser == ycid_pkg::CMD_LOAD)),
			.widx     (in_idx),
			.wday     (in_day),
			.wrate    (in_rate),
			.n        (n_eff),
			.nxt_day  (nd),
			.nxt_rate (nr),
			.day      (day_a[i]),
			.rate     (rate_a[i]),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	assign tok_end = tok[MAX_PILLARS];
	assign in_days = {1'b0, q_q} < 17'(MAX_DAYS);

	ycid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	ycid_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.f      (exp_f),
		.done   (exp_done),
		.e      (exp_e)
	);

	assign diff    = {r1_q[RW-1], r1_q} - {r0_q[RW-1], r0_q};
	assign num_abs = num_s1[49] ? (50'd0 - num_s1) : num_s1;
	assign p_abs   = p_s1[49] ? (50'd0 - p_s1) : p_s1;
	assign xpos    = p_s1[49];
	assign big_k   = xpos && (kk_q >= 6'd4);
	assign ln2_sub = (red_q >= ycid_pkg::DIV_W'(ycid_pkg::LN2_Q30)) && (kk_q < 6'd32);

	always_comb begin
		case (var_q)
			ycid_pkg::VAR_UP:   rr = {rate_q[RW-1], rate_q} + ycid_pkg::BP_Q30;
			ycid_pkg::VAR_DOWN: rr = {rate_q[RW-1], rate_q} - ycid_pkg::BP_Q30;
			default:            rr = {rate_q[RW-1], rate_q};
		endcase
	end

	always_comb begin
		if (xpos) begin
			exp_f = rem_q;
		end else if (rem_q == '0) begin
			exp_f = '0;
		end else begin
			exp_f = ycid_pkg::LN2_Q30 - rem_q;
		end
	end

	always_comb begin
		sh = 6'(kk_q[4:0]) + ((rem_q == '0) ? 6'd2 : 6'd3);
		if (xpos) begin
			case (kk_q[1:0])
				2'd0:    v = {1'b0, exp_e} >> 2;
				2'd1:    v = {1'b0, exp_e} >> 1;
				2'd2:    v = {1'b0, exp_e};
				default: v = {exp_e, 1'b0};
			endcase
		end else if (kk_q >= 6'd32) begin
			v = '0;
		end else begin
			v = {1'b0, exp_e} >> sh;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ycid_pkg::ST_IDLE: begin
				if (acc_in) begin
					st_d = (s_tuser == ycid_pkg::CMD_LOAD) ? ycid_pkg::ST_DONE
						: ycid_pkg::ST_SEARCH;
				end
			end
			ycid_pkg::ST_SEARCH: begin
				if (tok_end.valid) begin
					if (!tok_end.hit || !in_days) begin
						st_d = ycid_pkg::ST_DONE;
					end else if (tok_end.a == tok_end.b) begin
						st_d = ycid_pkg::ST_PMUL;
					end else begin
						st_d = ycid_pkg::ST_IMUL;
					end
				end
			end
			ycid_pkg::ST_IMUL:   st_d = ycid_pkg::ST_ISTART;
			ycid_pkg::ST_ISTART: st_d = ycid_pkg::ST_IWAIT;
			ycid_pkg::ST_IWAIT:  if (div_done) st_d = ycid_pkg::ST_PMUL;
			ycid_pkg::ST_PMUL:   st_d = ycid_pkg::ST_BSTART;
			ycid_pkg::ST_BSTART: st_d = ycid_pkg::ST_BWAIT;
			ycid_pkg::ST_BWAIT:  if (div_done) st_d = ycid_pkg::ST_LSTART;
			ycid_pkg::ST_LSTART: st_d = ycid_pkg::ST_LWAIT;
			ycid_pkg::ST_LWAIT:  if (!ln2_sub) st_d = ycid_pkg::ST_ESTART;
			ycid_pkg::ST_ESTART: st_d = big_k ? ycid_pkg::ST_NEXT : ycid_pkg::ST_EWAIT;
			ycid_pkg::ST_EWAIT:  if (exp_done) st_d = ycid_pkg::ST_NEXT;
			ycid_pkg::ST_NEXT: begin
				st_d = (var_q == ycid_pkg::VAR_DOWN) ? ycid_pkg::ST_DONE : ycid_pkg::ST_PMUL;
			end
			ycid_pkg::ST_DONE:   if (out_go) st_d = ycid_pkg::ST_IDLE;
			default:             st_d = ycid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		exp_start    = 1'b0;
		unique case (st_q)
			ycid_pkg::ST_IDLE: s_tready = 1'b1;
			ycid_pkg::ST_ISTART: begin
				div_start    = 1'b1;
				div_dividend = num_abs[47:0];
				div_divisor  = 30'(b_q - a_q);
			end
			ycid_pkg::ST_BSTART: begin
				div_start    = 1'b1;
				div_dividend = p_abs[47:0];
				div_divisor  = 30'(basis_eff);
			end
			ycid_pkg::ST_ESTART: exp_start = !big_k;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ycid_pkg::ST_IDLE;
			var_q      <= ycid_pkg::VAR_BASE;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ycid_pkg::ST_IDLE) begin
				var_q <= ycid_pkg::VAR_BASE;
			end else if (st_q == ycid_pkg::ST_NEXT) begin
				var_q <= var_q + 2'd1;
			end
			if (st_q == ycid_pkg::ST_DONE && out_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ycid_pkg::ST_IDLE: begin
				if (acc_in) begin
					q_q    <= in_q;
					rate_q <= '0;
					df_q   <= '{default: '0};
					oor_q  <= 1'b0;
					sat_q  <= 1'b0;
				end
			end
			ycid_pkg::ST_SEARCH: begin
				if (tok_end.valid) begin
					a_q  <= tok_end.a;
					b_q  <= tok_end.b;
					r0_q <= tok_end.r0;
					r1_q <= tok_end.r1;
					if (!tok_end.hit || !in_days) begin
						oor_q <= 1'b1;
						df_q  <= '{default: ycid_pkg::ONE_Q28};
					end else if (tok_end.a == tok_end.b) begin
						rate_q <= tok_end.r0;
					end
				end
			end
			ycid_pkg::ST_IMUL: begin
				num_s1 <= 50'($signed(diff) * $signed({1'b0, q_q - a_q}));
			end
			ycid_pkg::ST_IWAIT: begin
				if (div_done) begin
					rate_q <= num_s1[49] ? (r0_q - div_quot[31:0]) : (r0_q + div_quot[31:0]);
				end
			end
			ycid_pkg::ST_PMUL: begin
				p_s1 <= 50'($signed(rr) * $signed({1'b0, q_q}));
			end
			ycid_pkg::ST_BWAIT: if (div_done) mag_q <= div_quot;
			ycid_pkg::ST_LSTART: begin
				red_q <= mag_q;
				kk_q  <= '0;
			end
			ycid_pkg::ST_LWAIT: begin
				if (ln2_sub) begin
					red_q <= red_q - ycid_pkg::DIV_W'(ycid_pkg::LN2_Q30);
					kk_q  <= kk_q + 6'd1;
				end else begin
					rem_q <= red_q[ycid_pkg::DVS_W-1:0];
				end
			end
			ycid_pkg::ST_ESTART: begin
				if (big_k) begin
					df_q[var_q] <= ycid_pkg::DF_MAX;
					sat_q       <= 1'b1;
				end
			end
			ycid_pkg::ST_EWAIT: begin
				if (exp_done) begin
					if (v > {1'b0, ycid_pkg::DF_MAX}) begin
						df_q[var_q] <= ycid_pkg::DF_MAX;
						sat_q       <= 1'b1;
					end else begin
						df_q[var_q] <= v[31:0];
					end
				end
			end
			ycid_pkg::ST_DONE: begin
				if (out_go) begin
					m_tdata_q <= {df_q[2], df_q[1], df_q[0], rate_q};
					m_tuser_q <= {sat_q, oor_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: rtl/core/ycid_cell.sv
module ycid_cell #(
	parameter int IDX = 0,
	parameter int NW  = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [3:0]                 widx,
	input  logic [ycid_pkg::DAY_W-1:0] wday,
	input  logic [ycid_pkg::RATE_W-1:0] wrate,
	input  logic [NW-1:0]              n,
	input  logic [ycid_pkg::DAY_W-1:0] nxt_day,
	input  logic [ycid_pkg::RATE_W-1:0] nxt_rate,
	output logic [ycid_pkg::DAY_W-1:0] day,
	output logic [ycid_pkg::RATE_W-1:0] rate,
	input  ycid_pkg::tok_t             tok_in,
	output ycid_pkg::tok_t             tok_out
);

	logic [ycid_pkg::DAY_W-1:0]  day_q;
	logic [ycid_pkg::RATE_W-1:0] rate_q;
	ycid_pkg::tok_t              tok_q;
	ycid_pkg::tok_t              tok_d;
	logic                        last;
	logic                        in_use;
	logic                        hit;

	assign last   = (IDX + 2) == int'(n);
	assign in_use = (IDX + 2) <= int'(n);
	assign hit    = tok_in.valid && in_use && (day_q <= tok_in.q) &&
		((tok_in.q < nxt_day) || (last && (tok_in.q == nxt_day)));

	always_comb begin
		tok_d = tok_in;
		if (hit) begin
			tok_d.hit = 1'b1;
			tok_d.a   = day_q;
			tok_d.b   = nxt_day;
			tok_d.r0  = rate_q;
			tok_d.r1  = nxt_rate;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (32'(widx) == IDX)) begin
			day_q  <= wday;
			rate_q <= wrate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign day     = day_q;
	assign rate    = rate_q;
	assign tok_out = tok_q;

endmodule

FILE: rtl/core/ycid_div.sv
module ycid_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ycid_pkg::DIV_W-1:0] dividend,
	input  logic [ycid_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [ycid_pkg::DIV_W-1:0] quot
);

	localparam int DW = ycid_pkg::DIV_W;
	localparam int VW = ycid_pkg::DVS_W;
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          take;

	assign trial = {rem_q, quo_q[DW-1]};
	assign take  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DW-2:0], take};
			rem_q <= take ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

FILE: rtl/core/ycid_exp.sv
module ycid_exp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ycid_pkg::FRAC_W-1:0] f,
	output logic                        done,
	output logic [ycid_pkg::DF_W-1:0]   e
);

	localparam int FW = ycid_pkg::FRAC_W;

	ycid_pkg::exp_state_t st_q;
	ycid_pkg::exp_state_t st_d;
	logic [3:0]           n_q;
	logic [FW-1:0]        f_q;
	logic [FW:0]          term_q;
	logic [31:0]          sum_q;
	logic [60:0]          prod_s1;
	logic [60:0]          mq_s2;
	logic [FW-1:0]        tnew;
	ycid_pkg::recip_t     rc;

	assign rc   = ycid_pkg::recip(n_q);
	assign tnew = FW'(mq_s2 >> rc.sh);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ycid_pkg::EX_IDLE: if (start) st_d = ycid_pkg::EX_MUL;
			ycid_pkg::EX_MUL:  st_d = ycid_pkg::EX_REC;
			ycid_pkg::EX_REC:  st_d = ycid_pkg::EX_ACC;
			ycid_pkg::EX_ACC: begin
				st_d = (n_q == ycid_pkg::TAYLOR_N) ? ycid_pkg::EX_DONE : ycid_pkg::EX_MUL;
			end
			ycid_pkg::EX_DONE: st_d = ycid_pkg::EX_IDLE;
			default:           st_d = ycid_pkg::EX_IDLE;
		endcase
	end

	always_comb begin
		done = (st_q == ycid_pkg::EX_DONE);
		e    = sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ycid_pkg::EX_IDLE;
			n_q  <= 4'd1;
		end else begin
			st_q <= st_d;
			if (st_q == ycid_pkg::EX_IDLE && start) begin
				n_q <= 4'd1;
			end else if (st_q == ycid_pkg::EX_ACC) begin
				n_q <= n_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ycid_pkg::EX_IDLE: begin
				if (start) begin
					f_q    <= f;
					term_q <= ycid_pkg::ONE_Q30;
					sum_q  <= 32'(ycid_pkg::ONE_Q30);
				end
			end
			ycid_pkg::EX_MUL: prod_s1 <= 61'(term_q) * 61'(f_q);
			ycid_pkg::EX_REC: mq_s2 <= 61'(prod_s1[59:30]) * 61'(rc.m);
			ycid_pkg::EX_ACC: begin
				term_q <= {1'b0, tnew};
				sum_q  <= sum_q + 32'(tnew);
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/ycid_checker.sv
`include "assert_macros.svh"

module ycid_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [71:0]  s_tdata,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [1:0]   m_tuser
);

	`YCID_ASSERT_NXT(a_m_hold, m_tvalid && !m_tready, m_tvalid)
	`YCID_ASSERT_NXT(a_m_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	`YCID_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
	`YCID_ASSERT_IMP(a_oor_word, m_tvalid && m_tuser[0], (m_tdata[31:0] == 32'd0) && (m_tdata[63:32] == ycid_pkg::ONE_Q28) && (m_tdata[95:64] == ycid_pkg::ONE_Q28) && (m_tdata[127:96] == ycid_pkg::ONE_Q28) && !m_tuser[1])

endmodule

bind yield_curve_interp_discount ycid_checker u_ycid_checker (.*);

FILE: tb/tb_yield_curve_interp_discount.sv
`timescale 1ns / 1ps

module tb_yield_curve_interp_discount;

	localparam int NUM_SLOTS   = 16;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [31:0] BASIS_POINT = 32'd107374;
	localparam longint unsigned LN2 = 64'd744261118;

	typedef struct packed {
		logic [31:0] rate;
		logic [31:0] disc;
		logic [31:0] disc_up;
		logic [31:0] disc_dn;
		logic        oor;
		logic        sat;
	} curve_word_t;

	class curve_scoreboard;
		logic [15:0] days [NUM_SLOTS];
		logic [31:0] rates [NUM_SLOTS];
		int unsigned count_reg;
		int unsigned basis_reg;
		curve_word_t expected_q [$];
		int errors;

		function new();
			count_reg = 2;
			basis_reg = 365;
			errors = 0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				days[i] = '0;
				rates[i] = '0;
			end
		endfunction

		function void write_reg(logic idx, logic [9:0] data);
			if (idx == ycid_pkg::CFG_PILLAR_COUNT)
				count_reg = 32'(data[4:0]);
			else
				basis_reg = 32'(data);
		endfunction

		function longint unsigned discount(longint r, int unsigned q, int unsigned basis,
				inout bit sat);
			longint p;
			longint unsigned mag, kk, rem, f, term, sum, v;
			longint k, s;
			bit xpos;
			p = r * longint'(q);
			xpos = p < 0;
			mag = longint'(xpos ? -p : p);
			mag = mag / basis;
			kk = mag / LN2;
			if (xpos) begin
				if (kk >= 4) begin
					sat = 1;
					return 64'hFFFF_FFFF;
				end
				k = kk;
				f = mag - kk * LN2;
			end else begin
				rem = mag - kk * LN2;
				if (rem == 0) begin
					k = -longint'(kk);
					f = 0;
				end else begin
					k = -longint'(kk) - 1;
					f = LN2 - rem;
				end
			end
			term = 64'd1 << 30;
			sum = term;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * f) >> 30) / n;
				sum += term;
			end
			if (k >= 2)
				v = sum << (k - 2);
			else begin
				s = 2 - k;
				v = (s >= 63) ? 0 : (sum >> s);
			end
			if (v > 64'hFFFF_FFFF) begin
				sat = 1;
				return 64'hFFFF_FFFF;
			end
			return v;
		endfunction

		function void note(logic cmd, logic [3:0] idx, logic [15:0] day, logic [31:0] prate,
				logic [15:0] qday);
			curve_word_t e;
			int unsigned n, basis, q, a, b;
			int seg;
			longint r0, r1, num, rate;
			longint unsigned m;
			bit sat;
			e = '0;
			seg = -1;
			sat = 0;
			if (cmd == ycid_pkg::CMD_LOAD) begin
				days[idx] = day;
				rates[idx] = prate;
				expected_q.push_back(e);
				return;
			end
			n = count_reg < 2 ? 2 : (count_reg > NUM_SLOTS ? NUM_SLOTS : count_reg);
			basis = basis_reg == 0 ? 1 : basis_reg;
			q = 32'(qday);
			for (int i = 0; i + 1 < n; i++)
				if (days[i] <= q && (q < days[i+1] || (i + 2 == n && q == days[i+1])))
					seg = i;
			if (seg < 0) begin
				e.disc = ycid_pkg::ONE_Q28;
				e.disc_up = ycid_pkg::ONE_Q28;
				e.disc_dn = ycid_pkg::ONE_Q28;
				e.oor = 1;
				expected_q.push_back(e);
				return;
			end
			a = 32'(days[seg]);
			b = 32'(days[seg+1]);
			r0 = longint'($signed(rates[seg]));
			r1 = longint'($signed(rates[seg+1]));
			if (a == b)
				rate = r0;
			else begin
				num = (r1 - r0) * longint'(q - a);
				m = longint'(num < 0 ? -num : num);
				m = m / (b - a);
				rate = num < 0 ? r0 - longint'(m) : r0 + longint'(m);
			end
			e.disc = 32'(discount(rate, q, basis, sat));
			e.disc_up = 32'(discount(rate + BASIS_POINT, q, basis, sat));
			e.disc_dn = 32'(discount(rate - BASIS_POINT, q, basis, sat));
			e.rate = rate[31:0];
			e.sat = sat;
			expected_q.push_back(e);
		endfunction

		function void check(curve_word_t got);
			curve_word_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word rate=%h disc=%h", got.rate, got.disc);
				return;
			end
			e = expected_q.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp rate=%h df=%h up=%h dn=%h oor=%b sat=%b %s",
						e.rate, e.disc, e.disc_up, e.disc_dn, e.oor, e.sat,
						$sformatf("| got rate=%h df=%h up=%h dn=%h oor=%b sat=%b",
							got.rate, got.disc, got.disc_up, got.disc_dn,
							got.oor, got.sat));
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic         cfg_index = 0;
	logic [9:0]   cfg_data = '0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;
	logic         s_tuser = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;

	curve_scoreboard sb = new();
	int  cycles = 0;
	bit  hold_req = 0;
	logic [15:0] curve_days [NUM_SLOTS];

	yield_curve_interp_discount dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready)
			sb.check('{rate: m_tdata[31:0], disc: m_tdata[63:32], disc_up: m_tdata[95:64],
				disc_dn: m_tdata[127:96], oor: m_tuser[0], sat: m_tuser[1]});
	end

	initial begin
		int n;
		wait (arst_n);
		forever begin
			n = $urandom_range(0, 6);
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 0;
			end
			if (n > 0) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_word(logic cmd, logic [3:0] idx, logic [15:0] day, logic [31:0] prate,
			logic [15:0] qday);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, qday, prate, day, idx};
		do @(posedge clk); while (!s_tready);
		sb.note(cmd, idx, day, prate, qday);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [9:0] data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic load_curve(int span);
		logic [31:0] prate;
		int d;
		d = $urandom_range(0, 2000);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (d > 65535) d = 65535;
			curve_days[i] = 16'(d);
			case ($urandom_range(0, 3))
				0: prate = $urandom;
				1: prate = $urandom_range(0, 32'h0400_0000);
				default: prate = -$signed($urandom_range(0, 32'h0400_0000));
			endcase
			send_word(ycid_pkg::CMD_LOAD, 4'(i), 16'(d), prate, 16'($urandom));
			d += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, span);
		end
	endtask

	initial begin
		logic [9:0] cnt, basis;
		int last;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_cfg(ycid_pkg::CFG_PILLAR_COUNT, 10'd16);
		write_cfg(ycid_pkg::CFG_YEAR_BASIS, 10'd365);
		for (int i = 0; i < NUM_SLOTS; i++)
			send_word(ycid_pkg::CMD_LOAD, 4'(i), 16'(i * 4000),
				(i == 3) ? 32'h8000_0000 :
				(i == 7) ? 32'h7FFF_FFFF : 32'(32'h0100_0000 * i), 16'hFFFF);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'd0);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'd14000);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'd26001);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'd60000);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'd60001);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'hFFFF);
		drain();
		write_cfg(ycid_pkg::CFG_YEAR_BASIS, 10'd1);
		write_cfg(ycid_pkg::CFG_PILLAR_COUNT, 10'd2);
		send_word(ycid_pkg::CMD_LOAD, 4'd0, 16'd100, 32'h8000_0000, 16'd0);
		send_word(ycid_pkg::CMD_LOAD, 4'd1, 16'd100, 32'h7FFF_FFFF, 16'd0);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'd100);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'd99);
		send_word(ycid_pkg::CMD_LOAD, 4'd1, 16'hFFFF, 32'h8000_0000, 16'd0);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'hFFFE);
		send_word(ycid_pkg::CMD_QUERY, 4'd0, 16'd0, 32'd0, 16'hFFFF);
		drain();

		for (int ph = 0; ph < 13; ph++) begin
			case (ph % 5)
				0: cnt = 10'($urandom_range(2, 16));
				1: cnt = 10'd16;
				2: cnt = 10'd2;
				3: cnt = 10'($urandom_range(0, 1));
				default: cnt = 10'($urandom_range(17, 31));
			endcase
			case (ph % 4)
				0: basis = 10'($urandom_range(1, 1000));
				1: basis = 10'd0;
				2: basis = 10'd1000;
				default: basis = 10'($urandom_range(1001, 1023));
			endcase
			write_cfg(ycid_pkg::CFG_PILLAR_COUNT, cnt);
			write_cfg(ycid_pkg::CFG_YEAR_BASIS, basis);
			if (ph == 4) hold_req = 1;
			load_curve((ph % 3 == 0) ? 4000 : 300);
			last = (cnt < 2) ? 1 : (cnt > 16) ? 15 : int'(cnt) - 1;
			for (int j = 0; j < 40; j++) begin
				if ($urandom_range(0, 4) == 0)
					send_word(ycid_pkg::CMD_QUERY, 4'($urandom), 16'($urandom), $urandom,
						16'($urandom));
				else if ($urandom_range(0, 7) == 0)
					send_word(ycid_pkg::CMD_QUERY, 4'($urandom), 16'($urandom), $urandom,
						curve_days[$urandom_range(0, last)]);
				else
					send_word(ycid_pkg::CMD_QUERY, 4'($urandom), 16'($urandom), $urandom,
						16'($urandom_range(curve_days[0], curve_days[last])));
			end
			drain();
		end

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
